FILE: hdl/dsdpg_pkg.sv
package dsdpg_pkg;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF   = 2;
    localparam int SPEED_BITS_DEF = 16;

    // Number of channels that the channel field can address and the outputs show.
    localparam int ADDR_CHANNELS = 2;

    // Width of the step position counters.
    localparam int POS_BITS = 32;

    // Item operation codes.
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SET_SPEED = 1'b1;

    // Channel motion codes.
    localparam logic [1:0] DIR_STOP = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_REV  = 2'b11;

    // Per-channel command for the item being executed.
    typedef struct packed {
        logic tick;
        logic set;
    } ch_ctl_t;

    // Per-channel pin and position view after the item.
    typedef struct packed {
        logic                step;
        logic                dir;
        logic [POS_BITS-1:0] position;
    } ch_status_t;

endpackage

FILE: hdl/dsdpg_channel.sv
module dsdpg_channel #(
    parameter int SPEED_BITS = dsdpg_pkg::SPEED_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsdpg_pkg::ch_ctl_t            ctl,
    input  logic signed [SPEED_BITS-1:0]  speed,
    output dsdpg_pkg::ch_status_t         status_next
);
    import dsdpg_pkg::*;

    localparam int MAG_BITS = SPEED_BITS - 1;

    logic [1:0]            direction_reg, direction_next;
    logic [MAG_BITS-1:0]   high_time_reg, high_time_next;
    logic [MAG_BITS-1:0]   period_reg, period_next;
    logic [SPEED_BITS-1:0] phase_reg, phase_next;
    logic [POS_BITS-1:0]   position_reg, position_next;
    logic                  step_reg, step_next;
    logic                  dir_reg, dir_next;

    logic [SPEED_BITS-1:0] speed_neg;
    logic [MAG_BITS-1:0]   speed_mag;
    logic [SPEED_BITS-1:0] count_inc;

    // Magnitude of the requested speed; the most negative value saturates.
    assign speed_neg = (~$unsigned(speed)) + {{(SPEED_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        priority if (!speed[SPEED_BITS-1])
        begin
            speed_mag = speed[MAG_BITS-1:0];
        end
        else if (speed_neg[SPEED_BITS-1])
        begin
            speed_mag = '1;
        end
        else
        begin
            speed_mag = speed_neg[MAG_BITS-1:0];
        end
    end

    assign count_inc = phase_reg + {{(SPEED_BITS-1){1'b0}}, 1'b1};

    // Next state for a set-speed or a tick item.
    always_comb
    begin
        direction_next = direction_reg;
        high_time_next = high_time_reg;
        period_next    = period_reg;
        phase_next     = phase_reg;
        position_next  = position_reg;
        step_next      = step_reg;
        dir_next       = dir_reg;
        priority if (ctl.set)
        begin
            period_next    = speed_mag;
            high_time_next = speed_mag >> 1;
            priority if (speed == '0)
            begin
                direction_next = DIR_STOP;
            end
            else if (speed[SPEED_BITS-1])
            begin
                direction_next = DIR_REV;
                dir_next       = 1'b0;
            end
            else
            begin
                direction_next = DIR_FWD;
                dir_next       = 1'b1;
            end
        end
        else if (ctl.tick && (direction_reg != DIR_STOP))
        begin
            // The pin level uses the counter before any wrap.
            step_next = (count_inc <= {1'b0, high_time_reg});
            if (count_inc > {1'b0, period_reg})
            begin
                phase_next = '0;
                if (direction_reg == DIR_FWD)
                begin
                    position_next = position_reg + {{(POS_BITS-1){1'b0}}, 1'b1};
                end
                else
                begin
                    position_next = position_reg - {{(POS_BITS-1){1'b0}}, 1'b1};
                end
            end
            else
            begin
                phase_next = count_inc;
            end
        end
    end

    // Channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_STOP;
            high_time_reg <= '0;
            period_reg    <= '0;
            phase_reg     <= '0;
            position_reg  <= '0;
            step_reg      <= 1'b0;
            dir_reg       <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
            high_time_reg <= high_time_next;
            period_reg    <= period_next;
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            step_reg      <= step_next;
            dir_reg       <= dir_next;
        end
    end

    assign status_next.step     = step_next;
    assign status_next.dir      = dir_next;
    assign status_next.position = position_next;

endmodule

FILE: hdl/dual_step_dir_pulse_generator_unit.sv
// Step/direction pulse generator for stepper motors, channel 0 is the right
// motor and channel 1 the left motor.
// Input channel: in_valid/in_stall with operation, channel and speed. A tick
// item advances every moving channel by one timer tick; a set-speed item
// loads the selected channel's direction, period and high time from speed.
// Output channel: out_valid/out_stall with the step and direction pin levels
// and the step positions of both motors as they stand after the item.
// Every accepted item gives exactly one result item.
// The item is captured in an input register, and the channel state and the
// result register are then updated together from that input register.
// Throughput is one item per cycle while the receiver does not stall; the
// channel update is combinational logic per channel between those two registers.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; after that in_stall follows out_stall.
// Reset clears every channel to stopped, zero position and low pins, and
// empties both registers.
module dual_step_dir_pulse_generator_unit #(
    parameter int CHANNELS   = dsdpg_pkg::CHANNELS_DEF,
    parameter int SPEED_BITS = dsdpg_pkg::SPEED_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic                                 channel,
    input  logic signed [SPEED_BITS-1:0]         speed,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 step_right,
    output logic                                 step_left,
    output logic                                 dir_right,
    output logic                                 dir_left,
    output logic signed [dsdpg_pkg::POS_BITS-1:0] position_right,
    output logic signed [dsdpg_pkg::POS_BITS-1:0] position_left
);
    import dsdpg_pkg::*;

    logic                         in_valid_reg;
    logic                         op_reg;
    logic                         chan_reg;
    logic signed [SPEED_BITS-1:0] speed_reg;

    logic                         out_valid_reg;
    ch_status_t                   right_reg, left_reg;
    ch_status_t                   right_next, left_next;

    logic                         stage_advance;
    logic                         stage_fire;
    ch_status_t                   status_next [CHANNELS];

    // The input register moves on whenever the result register is empty or not stalled.
    assign stage_advance = !out_valid_reg || !out_stall;
    assign stage_fire    = in_valid_reg && stage_advance;
    assign in_stall      = in_valid_reg && !stage_advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg    <= operation;
            chan_reg  <= channel;
            speed_reg <= speed;
        end
    end

    // One update unit per channel.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_ch
        localparam bit   ADDRESSABLE = (i < ADDR_CHANNELS);
        localparam logic CH_BIT      = 1'(i);
        ch_ctl_t ctl;

        assign ctl.tick = stage_fire && (op_reg == OP_TICK);
        assign ctl.set  = stage_fire && (op_reg == OP_SET_SPEED) && ADDRESSABLE
                          && (chan_reg == CH_BIT);

        dsdpg_channel #(
            .SPEED_BITS (SPEED_BITS)
        ) u_channel (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .speed       (speed_reg),
            .status_next (status_next[i])
        );
    end

    // An absent left motor reads as zero.
    assign right_next = status_next[0];
    if (CHANNELS >= ADDR_CHANNELS)
    begin : g_left
        assign left_next = status_next[1];
    end
    else
    begin : g_no_left
        assign left_next = '0;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            right_reg     <= '0;
            left_reg      <= '0;
        end
        else
        begin
            if (stage_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (stage_fire)
            begin
                right_reg <= right_next;
                left_reg  <= left_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_right     = right_reg.step;
    assign step_left      = left_reg.step;
    assign dir_right      = right_reg.dir;
    assign dir_left       = left_reg.dir;
    assign position_right = $signed(right_reg.position);
    assign position_left  = $signed(left_reg.position);

endmodule

FILE: hdl/dsdpg_checker.sv
module dsdpg_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  step_right,
    input logic                                  dir_right,
    input logic signed [dsdpg_pkg::POS_BITS-1:0] position_right,
    input logic signed [dsdpg_pkg::POS_BITS-1:0] position_left
);
    import dsdpg_pkg::*;

    // A stalled result item stays and holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position_right)
            && $stable(step_right) && $stable(dir_right))
        else $error("stalled result item changed");

    // The input side only stalls when a full result register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // The left position moves by at most one step between successive samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (position_left == $past(position_left))
            || (position_left == $past(position_left) + 32'sd1)
            || (position_left == $past(position_left) - 32'sd1))
        else $error("left position jumped by more than one step");

    // A right step pulse starts on a tick that does not wrap the period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(step_right) |-> $stable(position_right))
        else $error("right step rose together with a position change");

endmodule

bind dual_step_dir_pulse_generator_unit dsdpg_checker u_dsdpg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .step_right     (step_right),
    .dir_right      (dir_right),
    .position_right (position_right),
    .position_left  (position_left)
);

FILE: test/tb_top.sv
module tb_top;
    import dsdpg_pkg::*;

    localparam int SPEED_BITS   = SPEED_BITS_DEF;
    localparam int SPD_MAX      = 2 ** (SPEED_BITS - 1) - 1;
    localparam int SPD_MIN      = -(2 ** (SPEED_BITS - 1));
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 100;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 800000;

    // Pin levels and step positions of both motors after one item.
    typedef struct {
        logic                       step_r;
        logic                       step_l;
        logic                       dir_r;
        logic                       dir_l;
        logic signed [POS_BITS-1:0] pos_r;
        logic signed [POS_BITS-1:0] pos_l;
    } motor_view_t;

    // One row of the directed stimulus; fixed rows carry their own result.
    typedef struct {
        logic                         op;
        logic                         ch;
        logic signed [SPEED_BITS-1:0] spd;
        bit                           fixed;
        motor_view_t                  want;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         operation = OP_TICK;
    logic                         channel = 1'b0;
    logic signed [SPEED_BITS-1:0] speed = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         step_right;
    logic                         step_left;
    logic                         dir_right;
    logic                         dir_left;
    logic signed [POS_BITS-1:0]   position_right;
    logic signed [POS_BITS-1:0]   position_left;

    // Motor state mirrored by the predictor.
    logic [1:0]                 motion      [ADDR_CHANNELS] = '{default: DIR_STOP};
    logic [SPEED_BITS-2:0]      period      [ADDR_CHANNELS] = '{default: '0};
    logic [SPEED_BITS-2:0]      half_period [ADDR_CHANNELS] = '{default: '0};
    logic [SPEED_BITS-1:0]      phase       [ADDR_CHANNELS] = '{default: '0};
    logic signed [POS_BITS-1:0] pos         [ADDR_CHANNELS] = '{default: '0};
    logic                       step_pin    [ADDR_CHANNELS] = '{default: 1'b0};
    logic                       dir_pin     [ADDR_CHANNELS] = '{default: 1'b0};

    motor_view_t pin_state_q[$];
    motor_view_t predicted;
    motor_view_t oldest;
    motor_view_t cur_want;
    motor_view_t no_view;
    bit          cur_fixed = 1'b0;

    stim_row_t plan[$];

    bit send_quiet    = 1'b0;
    bit recv_quiet    = 1'b0;
    bit long_hold_req = 1'b0;
    int hold_left     = 0;
    int stall_left    = 0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int n_ticks       = 0;
    int n_sets        = 0;
    int n_results     = 0;
    int n_stalled     = 0;

    dual_step_dir_pulse_generator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .channel        (channel),
        .speed          (speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .step_right     (step_right),
        .step_left      (step_left),
        .dir_right      (dir_right),
        .dir_left       (dir_left),
        .position_right (position_right),
        .position_left  (position_left)
    );

    always #6 clk = ~clk;

    // Applies one item to the mirrored motor state and returns the new view.
    function automatic motor_view_t advance_motors(logic op, logic ch,
                                                   logic signed [SPEED_BITS-1:0] spd);
        motor_view_t v;
        int          mag;
        int          c;
        if (op == OP_SET_SPEED) begin
            if (spd == 0) begin
                // Zero speed stops the motor but leaves its direction pin alone.
                motion[ch] = DIR_STOP;
                mag = 0;
            end
            else if (spd < 0) begin
                motion[ch] = DIR_REV;
                dir_pin[ch] = 1'b0;
                mag = -int'(spd);
                if (mag > SPD_MAX)
                    mag = SPD_MAX;
            end
            else begin
                motion[ch] = DIR_FWD;
                dir_pin[ch] = 1'b1;
                mag = int'(spd);
            end
            period[ch] = mag[SPEED_BITS-2:0];
            half_period[ch] = period[ch] >> 1;
        end
        else begin
            for (int i = 0; i < ADDR_CHANNELS; i++) begin
                if (motion[i] != DIR_STOP) begin
                    // The step level uses the counter before it wraps.
                    c = int'(phase[i]) + 1;
                    step_pin[i] = (c <= int'(half_period[i]));
                    if (c > int'(period[i])) begin
                        c = 0;
                        pos[i] = (motion[i] == DIR_FWD) ? pos[i] + 1 : pos[i] - 1;
                    end
                    phase[i] = c[SPEED_BITS-1:0];
                end
            end
        end
        v.step_r = step_pin[0];
        v.step_l = step_pin[1];
        v.dir_r  = dir_pin[0];
        v.dir_l  = dir_pin[1];
        v.pos_r  = pos[0];
        v.pos_l  = pos[1];
        return v;
    endfunction

    function automatic motor_view_t view(logic sr, logic sl, logic dr, logic dl,
                                         int pr, int pl);
        motor_view_t v;
        v.step_r = sr;
        v.step_l = sl;
        v.dir_r  = dr;
        v.dir_l  = dl;
        v.pos_r  = pr;
        v.pos_l  = pl;
        return v;
    endfunction

    function automatic stim_row_t row(logic op, logic ch, int spd);
        stim_row_t r;
        r.op    = op;
        r.ch    = ch;
        r.spd   = SPEED_BITS'(spd);
        r.fixed = 1'b0;
        r.want  = no_view;
        return r;
    endfunction

    function automatic stim_row_t row_fixed(logic op, logic ch, int spd, motor_view_t want);
        stim_row_t r;
        r = row(op, ch, spd);
        r.fixed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small magnitudes keep the counters wrapping often.
    function automatic logic signed [SPEED_BITS-1:0] pick_speed();
        int r;
        int mag;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 75) begin
            mag = $urandom_range(1, 24);
            return SPEED_BITS'(($urandom_range(0, 1) == 1) ? -mag : mag);
        end
        if (r < 90)
            return SPEED_BITS'($urandom);
        case ($urandom_range(0, 3))
            0:       return SPEED_BITS'(SPD_MAX);
            1:       return SPEED_BITS'(SPD_MIN);
            2:       return SPEED_BITS'(SPD_MIN + 1);
            default: return SPEED_BITS'(-1);
        endcase
    endfunction

    function automatic void check_field(string field, int want, int seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, seen);
            fail_count++;
        end
    endfunction

    // Offers one item after a random gap and returns once it is taken.
    task automatic send_item(logic op, logic ch, logic signed [SPEED_BITS-1:0] spd,
                             bit fixed, motor_view_t want);
        int gap;
        gap = idle_len(send_quiet);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        channel   <= ch;
        speed     <= spd;
        cur_fixed <= fixed;
        cur_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_TICK)
            n_ticks++;
        else
            n_sets++;
    endtask

    // Stops offering items and waits for every outstanding result.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pin_state_q.size() != 0)
            @(posedge clk);
    endtask

    // Predict on each accepted item, compare each accepted result.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predicted = advance_motors(operation, channel, speed);
                pin_state_q.push_back(cur_fixed ? cur_want : predicted);
            end
            if (in_valid && in_stall)
                n_stalled++;
            if (out_valid && !out_stall) begin
                if (pin_state_q.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    fail_count++;
                end
                else begin
                    oldest = pin_state_q.pop_front();
                    check_field("step_right", int'(oldest.step_r), int'(step_right));
                    check_field("step_left", int'(oldest.step_l), int'(step_left));
                    check_field("dir_right", int'(oldest.dir_r), int'(dir_right));
                    check_field("dir_left", int'(oldest.dir_l), int'(dir_left));
                    check_field("position_right", oldest.pos_r, position_right);
                    check_field("position_left", oldest.pos_l, position_left);
                    n_results++;
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    always begin
        @(negedge clk);
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
            stall_left = idle_len(recv_quiet);
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int ph;
        int k;
        no_view = view(1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        cur_want = no_view;

        // Directed rows: reset view, both signs, extremes, stop with held
        // direction, ignored tick fields, and a period cut below the counter.
        plan.push_back(row_fixed(OP_TICK, 1'b0, 0,
                                 view(1'b0, 1'b0, 1'b0, 1'b0, 0, 0)));
        plan.push_back(row_fixed(OP_SET_SPEED, 1'b0, 1,
                                 view(1'b0, 1'b0, 1'b1, 1'b0, 0, 0)));
        plan.push_back(row_fixed(OP_SET_SPEED, 1'b1, -1,
                                 view(1'b0, 1'b0, 1'b1, 1'b0, 0, 0)));
        plan.push_back(row(OP_TICK, 1'b0, 0));
        plan.push_back(row(OP_TICK, 1'b1, SPD_MIN));
        plan.push_back(row(OP_SET_SPEED, 1'b0, SPD_MAX));
        plan.push_back(row(OP_SET_SPEED, 1'b1, SPD_MIN));
        plan.push_back(row(OP_TICK, 1'b0, SPD_MAX));
        plan.push_back(row(OP_TICK, 1'b1, -1));
        plan.push_back(row(OP_SET_SPEED, 1'b0, 0));
        plan.push_back(row(OP_TICK, 1'b1, -1));
        plan.push_back(row(OP_SET_SPEED, 1'b1, 0));
        plan.push_back(row(OP_TICK, 1'b0, 0));
        plan.push_back(row(OP_SET_SPEED, 1'b0, 4));
        plan.push_back(row(OP_SET_SPEED, 1'b1, -6));
        for (k = 0; k < 5; k++)
            plan.push_back(row(OP_TICK, k[0], 0));
        plan.push_back(row(OP_SET_SPEED, 1'b1, -2));
        plan.push_back(row(OP_TICK, 1'b0, 0));
        plan.push_back(row(OP_SET_SPEED, 1'b0, 21845));
        plan.push_back(row(OP_SET_SPEED, 1'b1, -21846));
        plan.push_back(row(OP_TICK, 1'b1, 21845));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].op, plan[i].ch, plan[i].spd, plan[i].fixed, plan[i].want);

        // Random phases with changing idle patterns on both sides.
        for (ph = 0; ph < RANDOM_ITEMS / PHASE_ITEMS; ph++) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            if (ph == 8 || $urandom_range(0, 4) == 0)
                drain_results();
            if (ph == 4) begin
                // Back-to-back items against a long receiver hold-off.
                send_quiet = 1'b1;
                long_hold_req = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 80)
                    send_item(OP_TICK, 1'($urandom_range(0, 1)), SPEED_BITS'($urandom),
                              1'b0, no_view);
                else
                    send_item(OP_SET_SPEED, 1'($urandom_range(0, 1)), pick_speed(), 1'b0,
                              no_view);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d ticks and %0d speed changes on both motors, %0d results checked.",
                 n_ticks, n_sets, n_results);
        $display("Input side was held off for %0d cycles; final positions %0d and %0d.",
                 n_stalled, pos[0], pos[1]);
        if (fail_count == 0 && pin_state_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
